// File: rtl/eti_pkg.sv
// Shared constants, command/status structs and register codes for the
// escape-time fractal iterator. No dependencies.
package eti_pkg;

  // Field widths
  localparam int VALUE_BITS      = 32;
  localparam int FRACTION_BITS   = 16;
  localparam int COUNT_BITS      = 10;
  localparam int COLOUR_BITS     = 8;
  localparam int PRODUCT_BITS    = 2 * VALUE_BITS;
  localparam int CROSS_BITS      = 2 * (VALUE_BITS + 1);

  // Configuration port
  localparam int CFG_INDEX_BITS  = 4;
  localparam int CFG_DATA_BITS   = COUNT_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ITERATION_LIMIT = 4'd0,
    REG_FRACTAL_MODE    = 4'd1
  } reg_index_t;

  localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(50);
  localparam logic                  MODE_MANDELBROT   = 1'b0;
  localparam logic                  MODE_BURNING_SHIP = 1'b1;

  // Escape bound: 4.0 in the Q32.32 square domain, one bit wider than a square
  localparam logic [PRODUCT_BITS:0] ESCAPE_BOUND =
    (PRODUCT_BITS + 1)'(4) << (2 * FRACTION_BITS);

  // Colour scaling: count * 254 / (limit - 1) + 1, quotient never above 254
  localparam int COLOUR_SCALE    = 254;
  localparam int QUOT_BITS       = COLOUR_BITS;
  localparam int DIVIDEND_BITS   = COUNT_BITS + COLOUR_BITS;
  localparam int STEP_BITS       = $clog2(QUOT_BITS);
  localparam logic [COLOUR_BITS-1:0] COLOUR_INSIDE = '0;
  localparam logic [COLOUR_BITS-1:0] COLOUR_MAX    = '1;

  // Controller to iteration datapath
  typedef struct packed {
    logic load_point;
    logic iterate;
  } eti_dp_cmd_t;

  // Iteration datapath to controller
  typedef struct packed {
    logic stop;    // limit reached or point escaped
    logic in_set;  // colour index is zero
  } eti_dp_status_t;

  // Controller to colour divider
  typedef struct packed {
    logic load;
    logic step;
  } eti_div_cmd_t;

  // Colour divider to controller
  typedef struct packed {
    logic last;    // current step produces the final quotient bit
  } eti_div_status_t;

endpackage

// File: rtl/eti_channels.sv
// Valid/ready channel interfaces: point input, result output and
// configuration write. Depends on eti_pkg.
interface eti_point_if import eti_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] point_real;
  logic signed [VALUE_BITS-1:0] point_imag;

  modport source (output valid, output point_real, output point_imag, input ready);
  modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

interface eti_result_if import eti_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_BITS-1:0]  iteration_count;
  logic [COLOUR_BITS-1:0] colour_index;

  modport source (output valid, output iteration_count, output colour_index, input ready);
  modport sink   (input valid, input iteration_count, input colour_index, output ready);
endinterface

interface eti_cfg_if import eti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/eti_datapath.sv
// Iteration datapath: z registers, registered squares and cross product,
// escape compare and z update. Depends on eti_pkg.
module eti_datapath import eti_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  eti_dp_cmd_t                  cmd,
  input  logic signed [VALUE_BITS-1:0] point_real,
  input  logic signed [VALUE_BITS-1:0] point_imag,
  input  logic [COUNT_BITS-1:0]        limit,
  input  logic                         mode,
  output eti_dp_status_t               status,
  output logic [COUNT_BITS-1:0]        count
);

  logic [VALUE_BITS-1:0]          cr, ci, x, y;
  logic [VALUE_BITS-1:0]          mx, my;
  logic signed [VALUE_BITS:0]     ax, ay;
  logic [PRODUCT_BITS-1:0]        sqx, sqy;
  logic signed [CROSS_BITS-1:0]   xy_prod;
  logic [PRODUCT_BITS-1:0]        diff;
  logic [PRODUCT_BITS:0]          mag_sum;
  logic [VALUE_BITS-1:0]          x_next, y_next;
  logic                           escaped, at_limit;

  // Magnitudes; the magnitude of the most negative value is exact as unsigned
  assign mx = x[VALUE_BITS-1] ? (~x + VALUE_BITS'(1)) : x;
  assign my = y[VALUE_BITS-1] ? (~y + VALUE_BITS'(1)) : y;

  // Cross-product operands: signed parts, or magnitudes in burning-ship mode
  assign ax = (mode == MODE_BURNING_SHIP) ? $signed({1'b0, mx}) : $signed({x[VALUE_BITS-1], x});
  assign ay = (mode == MODE_BURNING_SHIP) ? $signed({1'b0, my}) : $signed({y[VALUE_BITS-1], y});

  // Register the three products every cycle
  always_ff @(posedge clk) begin
    sqx     <= mx * mx;
    sqy     <= my * my;
    xy_prod <= ax * ay;
  end

  // Escape test on the exact sum, then the wrapped update
  assign mag_sum  = {1'b0, sqx} + {1'b0, sqy};
  assign escaped  = mag_sum > ESCAPE_BOUND;
  assign at_limit = count >= limit;
  assign diff     = sqx - sqy;
  assign x_next   = diff[FRACTION_BITS +: VALUE_BITS] + cr;
  assign y_next   = xy_prod[FRACTION_BITS-1 +: VALUE_BITS] + ci;

  assign status.stop   = at_limit || escaped;
  assign status.in_set = at_limit || (limit < COUNT_BITS'(2));

  // Load point or advance one iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_point) begin
      count <= '0;
    end else if (cmd.iterate) begin
      count <= count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      cr <= point_real;
      ci <= point_imag;
      x  <= '0;
      y  <= '0;
    end else if (cmd.iterate) begin
      x <= x_next;
      y <= y_next;
    end
  end

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.iterate && !cmd.load_point |=> count == $past(count) + COUNT_BITS'(1))
    else $error("iteration count did not advance by one");

endmodule

// File: rtl/eti_colour_div.sv
// Restoring divider for the colour index: (count*254) / (limit-1),
// one quotient bit per step. Depends on eti_pkg.
module eti_colour_div import eti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  eti_div_cmd_t           cmd,
  input  logic [COUNT_BITS-1:0]  count,
  input  logic [COUNT_BITS-1:0]  limit,
  output eti_div_status_t        status,
  output logic [QUOT_BITS-1:0]   quotient
);

  logic [DIVIDEND_BITS-1:0] rem;
  logic [DIVIDEND_BITS-1:0] dsh;
  logic [STEP_BITS-1:0]     step_cnt;
  logic                     fits;

  assign fits        = rem >= dsh;
  assign status.last = step_cnt == STEP_BITS'(QUOT_BITS - 1);

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + STEP_BITS'(1);
    end
  end

  // Load scaled count and aligned divisor, then shift one bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem      <= DIVIDEND_BITS'(count) * DIVIDEND_BITS'(COLOUR_SCALE);
      dsh      <= DIVIDEND_BITS'(limit - COUNT_BITS'(1)) << (QUOT_BITS - 1);
      quotient <= '0;
    end else if (cmd.step) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[QUOT_BITS-2:0], fits};
    end
  end

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step && status.last && !cmd.load |=> quotient <= QUOT_BITS'(COLOUR_SCALE))
    else $error("colour quotient above scale");

endmodule

// File: rtl/eti_ctrl.sv
// Controller state machine: sequences point load, square/update
// iterations, colour division and result hand-off. Depends on eti_pkg.
module eti_ctrl import eti_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_ready,
  input  eti_dp_status_t  dp_status,
  input  eti_div_status_t div_status,
  input  logic            out_busy,
  output eti_dp_cmd_t     dp_cmd,
  output eti_div_cmd_t    div_cmd,
  output logic            load_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_DIV,
    S_FIN
  } state_t;

  state_t state, state_next;

  // Commands and next state
  always_comb begin
    state_next         = state;
    point_ready        = 1'b0;
    dp_cmd.load_point  = 1'b0;
    dp_cmd.iterate     = 1'b0;
    div_cmd.load       = 1'b0;
    div_cmd.step       = 1'b0;
    load_out           = 1'b0;
    case (state)
      S_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          dp_cmd.load_point = 1'b1;
          state_next        = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (!dp_status.stop) begin
          dp_cmd.iterate = 1'b1;
          state_next     = S_MUL;
        end else if (dp_status.in_set) begin
          state_next = S_FIN;
        end else begin
          div_cmd.load = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        div_cmd.step = 1'b1;
        if (div_status.last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_busy) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_stop_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && dp_status.stop |=> state == S_DIV || state == S_FIN)
    else $error("stopped iteration did not move to colour stage");

endmodule

// File: rtl/escape_time_fractal_iterator.sv
// Escape-time fractal iterator top level: configuration registers, output
// register, controller, datapath and colour divider. Depends on eti_pkg,
// eti_channels, eti_ctrl, eti_datapath and eti_colour_div.
//
// Each point c (Q16.16) iterates z = z^2 + c from zero, in Mandelbrot or
// burning-ship mode, until the iteration limit or |z|^2 > 4. Each iteration
// runs through S_MUL, where the three products (x^2, y^2, xy) are registered,
// then S_UPD, where the escape test and z update run; this loop sets the
// rate. The colour division runs when the point escapes before the limit
// (one quotient bit per cycle). The block takes one point at a time; the next
// point is accepted while the previous result waits in the output register.
// Configuration registers: index 0 iteration_limit (reset 50), index 1
// fractal_mode (0 Mandelbrot, 1 burning ship); write them only while idle.
module escape_time_fractal_iterator import eti_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  eti_cfg_if.sink      cfg,
  eti_point_if.sink    point,
  eti_result_if.source result
);

  logic [COUNT_BITS-1:0]  limit;
  logic                   mode;
  eti_dp_cmd_t            dp_cmd;
  eti_dp_status_t         dp_status;
  eti_div_cmd_t           div_cmd;
  eti_div_status_t        div_status;
  logic [COUNT_BITS-1:0]  count;
  logic [QUOT_BITS-1:0]   quotient;
  logic [QUOT_BITS:0]     colour_sum;
  logic [COLOUR_BITS-1:0] colour;
  logic                   out_busy;
  logic                   load_out;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      mode  <= MODE_MANDELBROT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ITERATION_LIMIT: limit <= cfg.data;
        REG_FRACTAL_MODE:    mode  <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  eti_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .dp_status   (dp_status),
    .div_status  (div_status),
    .out_busy    (out_busy),
    .dp_cmd      (dp_cmd),
    .div_cmd     (div_cmd),
    .load_out    (load_out)
  );

  eti_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .point_real (point.point_real),
    .point_imag (point.point_imag),
    .limit      (limit),
    .mode       (mode),
    .status     (dp_status),
    .count      (count)
  );

  eti_colour_div u_colour_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .count    (count),
    .limit    (limit),
    .status   (div_status),
    .quotient (quotient)
  );

  // Offset quotient by one and clamp at the top of the range; in-set points get zero
  assign colour_sum = {1'b0, quotient} + (QUOT_BITS + 1)'(1);
  assign colour     = dp_status.in_set ? COLOUR_INSIDE :
                      colour_sum[QUOT_BITS] ? COLOUR_MAX : colour_sum[COLOUR_BITS-1:0];

  // Output register: hold until the transaction completes
  assign out_busy = result.valid && !result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.iteration_count <= count;
      result.colour_index    <= colour;
    end
  end

  a_one_point: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> !point.ready)
    else $error("second point accepted while one is in flight");

endmodule
